// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/bqns_pkg.sv
// ----------------------------------------------------------------------------
// bqns_pkg
// Types and constants shared by the ball query neighbor select block.
// ----------------------------------------------------------------------------
`default_nettype none

package bqns_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_SAMPLES  = 32;
    localparam int COORD_W      = 16;
    localparam int SLOT_W       = $clog2(MAX_POINTS);
    localparam int COUNT_W      = SLOT_W + 1;
    localparam int LIMIT_W      = $clog2(MAX_SAMPLES) + 1;
    localparam int HIT_IDX_W    = $clog2(MAX_SAMPLES);
    localparam int RADIUS_W     = 36;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int POINT_W      = 3 * COORD_W;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = RADIUS_W;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RADIUS_SQ    = 2'd0,
        CFG_SAMPLE_LIMIT = 2'd1,
        CFG_POINT_COUNT  = 2'd2
    } t_cfg_index;

    // One decoded request, as queued between front and back.
    typedef struct packed {
        t_cmd                        cmd;
        logic [SLOT_W-1:0]           slot;
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic signed [COORD_W-1:0]   z;
        logic [LIMIT_W-1:0]          limit;
        logic [COUNT_W-1:0]          count;
    } t_req;

    typedef struct packed {
        logic                busy;
        logic [LIMIT_W-1:0]  hits;
        logic [LIMIT_W-1:0]  limit;
    } t_back_stat;

endpackage

`default_nettype wire

// File: rtl/bqns_front.sv
// ----------------------------------------------------------------------------
// bqns_front
// Accepts requests, decodes the command and clamps the scan settings.
// ----------------------------------------------------------------------------
`default_nettype none

module bqns_front (
    input  wire logic                               push,
    input  wire logic                               i_fifo_full,
    input  wire logic                               i_command,
    input  wire logic [bqns_pkg::SLOT_W-1:0]        i_point_slot,
    input  wire logic signed [bqns_pkg::COORD_W-1:0] i_coord_x,
    input  wire logic signed [bqns_pkg::COORD_W-1:0] i_coord_y,
    input  wire logic signed [bqns_pkg::COORD_W-1:0] i_coord_z,
    input  wire logic [bqns_pkg::LIMIT_W-1:0]       i_sample_limit,
    input  wire logic [bqns_pkg::COUNT_W-1:0]       i_point_count,
    output logic                                    o_enq,
    output bqns_pkg::t_req                          o_req
);
    import bqns_pkg::*;

    logic [LIMIT_W-1:0] w_limit;
    logic [COUNT_W-1:0] w_count;

    // Clamp slot limit to 1..MAX_SAMPLES and point count to MAX_POINTS.
    always_comb begin
        if (i_sample_limit == '0) begin
            w_limit = LIMIT_W'(1);
        end else if (i_sample_limit > LIMIT_W'(MAX_SAMPLES)) begin
            w_limit = LIMIT_W'(MAX_SAMPLES);
        end else begin
            w_limit = i_sample_limit;
        end
        if (i_point_count > COUNT_W'(MAX_POINTS)) begin
            w_count = COUNT_W'(MAX_POINTS);
        end else begin
            w_count = i_point_count;
        end
    end

    always_comb begin
        o_req.cmd   = (i_command == 1'b1) ? CMD_QUERY : CMD_LOAD;
        o_req.slot  = i_point_slot;
        o_req.x     = i_coord_x;
        o_req.y     = i_coord_y;
        o_req.z     = i_coord_z;
        o_req.limit = w_limit;
        o_req.count = w_count;
    end

    assign o_enq = push && !i_fifo_full;

endmodule

`default_nettype wire

// File: rtl/bqns_req_fifo.sv
// ----------------------------------------------------------------------------
// bqns_req_fifo
// Short request queue between the front and the scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bqns_req_fifo (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_enq,
    input  wire bqns_pkg::t_req                   i_req,
    input  wire logic                             i_deq,
    output bqns_pkg::t_req                        o_req,
    output logic                                  o_full,
    output logic                                  o_valid,
    output logic [bqns_pkg::FIFO_CNT_W-1:0]       o_count
);
    import bqns_pkg::*;

    t_req                  r_entry [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_enq && !(i_deq && r_count != '0)) begin
            n_count = r_count + FIFO_CNT_W'(1);
        end else if (!i_enq && i_deq && r_count != '0) begin
            n_count = r_count - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_enq) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_deq && r_count != '0) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_entry[r_wr_ptr] <= i_req;
        end
    end

    assign o_req   = r_entry[r_rd_ptr];
    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

// File: rtl/bqns_back.sv
// ----------------------------------------------------------------------------
// bqns_back
// Point store, distance pipeline, hit collection and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bqns_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_req_valid,
    input  wire bqns_pkg::t_req                   i_req,
    output logic                                  o_req_deq,
    input  wire logic [bqns_pkg::RADIUS_W-1:0]    i_radius_sq,
    input  wire logic                             pop,
    output logic                                  empty,
    output logic [bqns_pkg::SLOT_W-1:0]           o_sample_index,
    output logic [bqns_pkg::LIMIT_W-1:0]          o_found_count,
    output logic                                  o_last,
    output bqns_pkg::t_back_stat                  o_stat
);
    import bqns_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                    r_state;
    logic [POINT_W-1:0]        r_mem [MAX_POINTS];
    logic [COUNT_W-1:0]        r_addr;
    logic [COUNT_W-1:0]        r_count;
    logic [LIMIT_W-1:0]        r_limit;
    logic [LIMIT_W-1:0]        r_hits;
    logic [LIMIT_W-1:0]        r_k;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic signed [COORD_W-1:0] r_cz;
    logic [SLOT_W-1:0]         r_first;
    logic [SLOT_W-1:0]         r_hit_buf [MAX_SAMPLES];

    logic                      r_v1, r_v2, r_v3, r_v4;
    logic [SLOT_W-1:0]         r_j1, r_j2, r_j3, r_j4;
    logic [POINT_W-1:0]        r_rd_data;
    logic signed [DIFF_W-1:0]  r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]           r_sx, r_sy, r_sz;
    logic [SUM_W-1:0]          r_sum;

    logic                      r_out_valid;
    logic [SLOT_W-1:0]         r_out_idx;
    logic [LIMIT_W-1:0]        r_out_cnt;
    logic                      r_out_last;

    logic                      w_take;
    logic                      w_load;
    logic                      w_issue;
    logic                      w_hit;
    logic                      w_emit;
    logic                      w_emit_last;
    logic                      w_pipe_busy;
    logic signed [COORD_W-1:0] w_px, w_py, w_pz;
    logic signed [SQ_W-1:0]    w_qx, w_qy, w_qz;
    logic [SLOT_W-1:0]         w_sel_idx;

    assign w_take      = (r_state == ST_IDLE) && i_req_valid;
    assign w_load      = w_take && (i_req.cmd == CMD_LOAD);
    assign w_issue     = (r_state == ST_SCAN) && (r_addr < r_count) && (r_hits < r_limit);
    assign w_hit       = r_v4 && (r_sum < i_radius_sq) && (r_hits < r_limit);
    assign w_emit      = (r_state == ST_EMIT) && (!r_out_valid || pop);
    assign w_emit_last = (r_k == r_limit - LIMIT_W'(1));
    assign w_pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_req_deq   = w_take;

    // Point store: one write port for loads, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[i_req.slot] <= {i_req.x, i_req.y, i_req.z};
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_addr[SLOT_W-1:0]];
        end
    end

    assign w_px = r_rd_data[3*COORD_W-1:2*COORD_W];
    assign w_py = r_rd_data[2*COORD_W-1:COORD_W];
    assign w_pz = r_rd_data[COORD_W-1:0];
    assign w_qx = r_dx * r_dx;
    assign w_qy = r_dy * r_dy;
    assign w_qz = r_dz * r_dz;

    // Distance pipeline: read, difference, square, sum.
    always_ff @(posedge i_clk) begin
        r_j1  <= r_addr[SLOT_W-1:0];
        r_j2  <= r_j1;
        r_j3  <= r_j2;
        r_j4  <= r_j3;
        r_dx  <= DIFF_W'(w_px) - DIFF_W'(r_cx);
        r_dy  <= DIFF_W'(w_py) - DIFF_W'(r_cy);
        r_dz  <= DIFF_W'(w_pz) - DIFF_W'(r_cz);
        r_sx  <= $unsigned(w_qx);
        r_sy  <= $unsigned(w_qy);
        r_sz  <= $unsigned(w_qz);
        r_sum <= SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_req.cmd == CMD_QUERY) begin
            r_cx    <= i_req.x;
            r_cy    <= i_req.y;
            r_cz    <= i_req.z;
            r_count <= i_req.count;
            r_limit <= i_req.limit;
        end
        if (w_hit) begin
            r_hit_buf[r_hits[HIT_IDX_W-1:0]] <= r_j4;
            if (r_hits == '0) begin
                r_first <= r_j4;
            end
        end
    end

    // Pick the slot value: a kept hit, else the first hit, else index zero.
    always_comb begin
        if (r_k < r_hits) begin
            w_sel_idx = r_hit_buf[r_k[HIT_IDX_W-1:0]];
        end else if (r_hits != '0) begin
            w_sel_idx = r_first;
        end else begin
            w_sel_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_idx  <= w_sel_idx;
            r_out_cnt  <= r_hits;
            r_out_last <= w_emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_hits      <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (w_hit) begin
                r_hits <= r_hits + LIMIT_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_take && i_req.cmd == CMD_QUERY) begin
                        r_addr  <= '0;
                        r_hits  <= '0;
                        r_k     <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_issue) begin
                        r_addr <= r_addr + COUNT_W'(1);
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!w_pipe_busy) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_k <= r_k + LIMIT_W'(1);
                        if (w_emit_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign empty          = !r_out_valid;
    assign o_sample_index = r_out_idx;
    assign o_found_count  = r_out_cnt;
    assign o_last         = r_out_last;

    always_comb begin
        o_stat.busy  = (r_state != ST_IDLE);
        o_stat.hits  = r_hits;
        o_stat.limit = r_limit;
    end

endmodule

`default_nettype wire

// File: rtl/ball_query_neighbor_select.sv
// ----------------------------------------------------------------------------
// ball_query_neighbor_select
// Ball query over a loadable point store: keeps the first neighbors of a
// centroid within a squared radius and returns one index per neighbor slot.
//
// Channel   Direction  Handshake               Payload
// request   in         push / full             command, point_slot, coord_x/y/z
// result    out        empty / pop             sample_index, found_count, last
// config    in         i_cfg_we (no wait)      i_cfg_index, i_cfg_data
//
// A load is written to the point store when the scan engine takes it. A
// query scans up to point_count points (fewer once sample_limit hits are
// kept), leaves the scan and drains the pipeline, then emits sample_limit
// results, one result per cycle while results are popped. The scan is
// bound by the single read port of the point store.
// Reset is synchronous and active low; the point store is not cleared.
// Requests queue ahead of the scan engine while it works or while results
// stall, so full rises only when four requests wait.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ball_query_neighbor_select (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                i_command,
    input  wire logic [bqns_pkg::SLOT_W-1:0]         i_point_slot,
    input  wire logic signed [bqns_pkg::COORD_W-1:0] i_coord_x,
    input  wire logic signed [bqns_pkg::COORD_W-1:0] i_coord_y,
    input  wire logic signed [bqns_pkg::COORD_W-1:0] i_coord_z,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [bqns_pkg::SLOT_W-1:0]              o_sample_index,
    output logic [bqns_pkg::LIMIT_W-1:0]             o_found_count,
    output logic                                     o_last,
    input  wire logic                                i_cfg_we,
    input  wire logic [bqns_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [bqns_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bqns_pkg::*;

    logic [RADIUS_W-1:0]   r_radius_sq;
    logic [LIMIT_W-1:0]    r_sample_limit;
    logic [COUNT_W-1:0]    r_point_count;

    logic                  w_enq;
    t_req                  w_front_req;
    t_req                  w_head_req;
    logic                  w_head_valid;
    logic                  w_deq;
    logic [FIFO_CNT_W-1:0] w_fifo_count;
    t_back_stat            w_stat;

    // Config registers; writes to an index past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_sq    <= '0;
            r_sample_limit <= LIMIT_W'(MAX_SAMPLES);
            r_point_count  <= COUNT_W'(MAX_POINTS);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RADIUS_SQ:    r_radius_sq    <= i_cfg_data[RADIUS_W-1:0];
                CFG_SAMPLE_LIMIT: r_sample_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_POINT_COUNT:  r_point_count  <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: decode the command and clamp the scan settings per request.
    bqns_front u_front (
        .push           (push),
        .i_fifo_full    (full),
        .i_command      (i_command),
        .i_point_slot   (i_point_slot),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_sample_limit (r_sample_limit),
        .i_point_count  (r_point_count),
        .o_enq          (w_enq),
        .o_req          (w_front_req)
    );

    // Hold decoded requests while the scan engine is busy.
    bqns_req_fifo u_req_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (w_enq),
        .i_req   (w_front_req),
        .i_deq   (w_deq),
        .o_req   (w_head_req),
        .o_full  (full),
        .o_valid (w_head_valid),
        .o_count (w_fifo_count)
    );

    // Back: store loads, scan queries and drive the result register.
    bqns_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (w_head_valid),
        .i_req          (w_head_req),
        .o_req_deq      (w_deq),
        .i_radius_sq    (r_radius_sq),
        .pop            (pop),
        .empty          (empty),
        .o_sample_index (o_sample_index),
        .o_found_count  (o_found_count),
        .o_last         (o_last),
        .o_stat         (w_stat)
    );

    // Kept hits never pass the slot limit of the running query.
    `CHK_IMPLY(a_hits_within_limit, i_clk, i_rst_n, w_stat.busy, w_stat.hits <= w_stat.limit)
    // An accepted request always lands in the queue.
    `CHK_NEXT(a_push_lands, i_clk, i_rst_n, push && !full, w_fifo_count != '0)

endmodule

`default_nettype wire
